>>> design/las_pkg.sv
// Package for the launcher arm sequencer: mode codes, register indexes,
// reset values and the shared configuration and button types.
// No dependencies; every other design file depends on it.
`default_nettype none

package las_pkg;

	// Default converter sample width.
	localparam int SAMPLE_BITS_DEF = 10;

	// Mode codes.
	localparam logic [3:0] M_FIND_TOP   = 4'd0;
	localparam logic [3:0] M_HOME       = 4'd1;
	localparam logic [3:0] M_HOME_ABOVE = 4'd2;
	localparam logic [3:0] M_HOME_BELOW = 4'd3;
	localparam logic [3:0] M_LOCKED     = 4'd4;
	localparam logic [3:0] M_FLOOR      = 4'd5;
	localparam logic [3:0] M_BRAKING    = 4'd6;
	localparam logic [3:0] M_LOADED     = 4'd7;
	localparam logic [3:0] M_ARMED      = 4'd8;
	localparam logic [3:0] M_LAUNCHING  = 4'd9;
	localparam logic [3:0] M_IDLE       = 4'd10;

	// Configuration register indexes.
	localparam logic [2:0] R_FLOOR_OFFSET = 3'd0;
	localparam logic [2:0] R_HOME_OFFSET  = 3'd1;
	localparam logic [2:0] R_HOME_WINDOW  = 3'd2;
	localparam logic [2:0] R_TOP_MARGIN   = 3'd3;
	localparam logic [2:0] R_SETTLE_TICKS = 3'd4;
	localparam logic [2:0] R_BRAKE_HOLD   = 3'd5;
	localparam logic [2:0] R_LOCK_TICKS   = 3'd6;
	localparam logic [2:0] R_HOME_DRIVE   = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Reset values.
	localparam logic [11:0]       FLOOR_OFFSET_RST = 12'd2300;
	localparam logic [11:0]       HOME_OFFSET_RST  = 12'd850;
	localparam logic [7:0]        HOME_WINDOW_RST  = 8'd25;
	localparam logic [11:0]       TOP_MARGIN_RST   = 12'd100;
	localparam logic [7:0]        SETTLE_TICKS_RST = 8'd9;
	localparam logic [7:0]        BRAKE_HOLD_RST   = 8'd10;
	localparam logic [7:0]        LOCK_TICKS_RST   = 8'd7;
	localparam logic signed [7:0] HOME_DRIVE_RST   = -8'sd64;
	localparam int                TOP_RESET        = 1500;

	// Motor commands.
	localparam logic signed [7:0] DRIVE_FULL_UP   = 8'sd127;
	localparam logic signed [7:0] DRIVE_FULL_DOWN = -8'sd127;
	localparam logic signed [7:0] DRIVE_MOST_NEG  = -8'sd128;

	// Wheel readings above this enable the brake override.
	localparam logic [7:0] WHEEL_THRESHOLD = 8'd127;

	typedef struct packed {
		logic [11:0]       floor_offset;
		logic [11:0]       home_offset;
		logic [7:0]        home_window;
		logic [11:0]       top_margin;
		logic [7:0]        settle_ticks;
		logic [7:0]        brake_hold_ticks;
		logic [7:0]        lock_ticks;
		logic signed [7:0] home_drive;
	} cfg_t;

	typedef struct packed {
		logic       go_home;
		logic       go_floor;
		logic       go_idle;
		logic       arm_request;
		logic       launch_request;
		logic [7:0] override_wheel;
		logic       override_open;
	} btn_t;

endpackage

`default_nettype wire

>>> design/las_if.sv
// Request channel interfaces for the launcher arm sequencer: the sample
// channel into the block and the result channel out of it.
// Depends on las_pkg for the default sample width.
`default_nettype none

interface las_sample_if #(
	parameter int SAMPLE_BITS = las_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] pot_sample;
	logic                   go_home;
	logic                   go_floor;
	logic                   go_idle;
	logic                   arm_request;
	logic                   launch_request;
	logic [7:0]             override_wheel;
	logic                   override_open;

	modport source (
		output valid, pot_sample, go_home, go_floor, go_idle, arm_request,
		       launch_request, override_wheel, override_open,
		input  ready
	);
	modport sink (
		input  valid, pot_sample, go_home, go_floor, go_idle, arm_request,
		       launch_request, override_wheel, override_open,
		output ready
	);
endinterface

interface las_result_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] motor_drive;
	logic              brake_release;
	logic [3:0]        mode;
	logic              launch_enabled;
	logic [11:0]       top_position;

	modport source (
		output valid, motor_drive, brake_release, mode, launch_enabled,
		       top_position,
		input  ready
	);
	modport sink (
		input  valid, motor_drive, brake_release, mode, launch_enabled,
		       top_position,
		output ready
	);
endinterface

`default_nettype wire

>>> design/las_cfg.sv
// Configuration register bank of the launcher arm sequencer.
// Depends on las_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module las_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [las_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [las_pkg::CFG_DATA_W-1:0] cfg_data,
	output las_pkg::cfg_t                       cfg
);
	import las_pkg::*;

	cfg_t cfg_q;

	// Write decoder; registers take the low bits of the data word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_offset     <= FLOOR_OFFSET_RST;
			cfg_q.home_offset      <= HOME_OFFSET_RST;
			cfg_q.home_window      <= HOME_WINDOW_RST;
			cfg_q.top_margin       <= TOP_MARGIN_RST;
			cfg_q.settle_ticks     <= SETTLE_TICKS_RST;
			cfg_q.brake_hold_ticks <= BRAKE_HOLD_RST;
			cfg_q.lock_ticks       <= LOCK_TICKS_RST;
			cfg_q.home_drive       <= HOME_DRIVE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				R_FLOOR_OFFSET: cfg_q.floor_offset     <= cfg_data[11:0];
				R_HOME_OFFSET:  cfg_q.home_offset      <= cfg_data[11:0];
				R_HOME_WINDOW:  cfg_q.home_window      <= cfg_data[7:0];
				R_TOP_MARGIN:   cfg_q.top_margin       <= cfg_data[11:0];
				R_SETTLE_TICKS: cfg_q.settle_ticks     <= cfg_data[7:0];
				R_BRAKE_HOLD:   cfg_q.brake_hold_ticks <= cfg_data[7:0];
				R_LOCK_TICKS:   cfg_q.lock_ticks       <= cfg_data[7:0];
				R_HOME_DRIVE:   cfg_q.home_drive       <= signed'(cfg_data[7:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/las_core.sv
// Sequencer state and per-tick update of the launcher arm sequencer, with
// the result register. Depends on las_pkg for mode codes, cfg_t and btn_t.
`default_nettype none

module las_core #(
	parameter int SAMPLE_BITS = las_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire las_pkg::cfg_t          cfg,
	input  wire logic                   step,
	input  wire logic [SAMPLE_BITS-1:0] pot_sample,
	input  wire las_pkg::btn_t          btn,
	output logic signed [7:0]           motor_drive,
	output logic                        brake_release,
	output logic [3:0]                  mode,
	output logic                        launch_enabled,
	output logic [11:0]                 top_position
);
	import las_pkg::*;

	// Reading width, top register width and signed compare width.
	localparam int RW = SAMPLE_BITS + 2;
	localparam int TW = (RW > 12) ? RW : 12;
	localparam int SW = TW + 2;
	localparam logic [TW-1:0] TOP_RST = TW'(TOP_RESET);

	logic [3:0]        mode_q;
	logic [RW-1:0]     prev_q;
	logic [TW-1:0]     top_q;
	logic [7:0]        settle_q, brake_cnt_q, lock_q;
	logic signed [7:0] motor_q;
	logic              brake_q;
	logic              launch_q;

	logic [3:0]        mode_d;
	logic [TW-1:0]     top_d;
	logic [7:0]        settle_d, brake_cnt_d, lock_d, settle_inc;
	logic signed [7:0] motor_d, motor_clamped;
	logic              brake_d, brake_out, launch_d;

	logic [RW-1:0]        pot;
	logic signed [SW-1:0] spot, top_s, home_pos, floor_pos, window_lim, cutoff;

	// Scaled reading and signed positions derived from the calibrated top.
	assign pot        = {pot_sample, 2'b00};
	assign spot       = signed'({{(SW-RW){1'b0}}, pot});
	assign top_s      = signed'({2'b00, top_q});
	assign home_pos   = top_s - signed'({{(SW-12){1'b0}}, cfg.home_offset});
	assign floor_pos  = top_s - signed'({{(SW-12){1'b0}}, cfg.floor_offset});
	assign window_lim = home_pos + signed'({{(SW-8){1'b0}}, cfg.home_window});
	assign cutoff     = top_s - signed'({{(SW-12){1'b0}}, cfg.top_margin});
	assign settle_inc = settle_q + 8'd1;

	// Next state for one tick.
	always_comb begin
		mode_d      = mode_q;
		top_d       = top_q;
		settle_d    = settle_q;
		brake_cnt_d = brake_cnt_q;
		lock_d      = lock_q;
		motor_d     = motor_q;
		brake_d     = brake_q;

		// Buttons: the later one in the order home, floor, idle wins.
		if (btn.go_home)  mode_d = M_HOME;
		if (btn.go_floor) mode_d = M_FLOOR;
		if (btn.go_idle)  mode_d = M_IDLE;

		launch_d = (mode_d == M_LAUNCHING) ? launch_q : 1'b0;

		unique case (mode_d)
			M_FIND_TOP: begin
				motor_d = '0;
				brake_d = 1'b1;
				if (pot == prev_q) begin
					settle_d = settle_inc;
					if (settle_inc >= cfg.settle_ticks) begin
						top_d  = TW'(pot);
						mode_d = M_IDLE;
					end
				end else begin
					settle_d = '0;
				end
			end
			M_HOME: begin
				mode_d = (spot > home_pos) ? M_HOME_ABOVE : M_HOME_BELOW;
			end
			M_HOME_ABOVE: begin
				brake_d = 1'b1;
				motor_d = cfg.home_drive;
				if (spot <= window_lim) begin
					brake_d = 1'b0;
					if (lock_q > cfg.lock_ticks) mode_d = M_LOCKED;
					lock_d = lock_q + 8'd1;
				end
			end
			M_HOME_BELOW: begin
				mode_d = M_IDLE;
			end
			M_LOCKED: begin
				lock_d  = '0;
				brake_d = 1'b0;
				motor_d = '0;
			end
			M_FLOOR: begin
				brake_d = 1'b1;
				motor_d = DRIVE_FULL_DOWN;
				if (spot <= floor_pos) begin
					brake_d     = 1'b0;
					mode_d      = M_BRAKING;
					brake_cnt_d = '0;
				end
			end
			M_BRAKING: begin
				brake_d = 1'b0;
				motor_d = DRIVE_FULL_DOWN;
				if (brake_cnt_q > cfg.brake_hold_ticks) mode_d = M_LOADED;
				brake_cnt_d = brake_cnt_q + 8'd1;
			end
			M_LOADED: begin
				brake_cnt_d = '0;
				motor_d     = '0;
				brake_d     = 1'b0;
				if (btn.arm_request) mode_d = M_ARMED;
			end
			M_ARMED: begin
				brake_d = 1'b0;
				motor_d = '0;
				if (btn.launch_request) mode_d = M_LAUNCHING;
			end
			M_LAUNCHING: begin
				brake_d  = 1'b1;
				launch_d = 1'b1;
				motor_d  = DRIVE_FULL_UP;
				if (spot >= cutoff) mode_d = M_IDLE;
			end
			M_IDLE: begin
				motor_d  = '0;
				brake_d  = 1'b1;
				settle_d = '0;
			end
			default: begin
				mode_d = M_IDLE;
			end
		endcase

		// The wheel override forces the brake and is kept as state.
		brake_out = brake_d;
		if (btn.override_wheel > WHEEL_THRESHOLD) brake_out = btn.override_open;

		motor_clamped = (motor_d == DRIVE_MOST_NEG) ? DRIVE_FULL_DOWN : motor_d;
	end

	// State registers, updated once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_FIND_TOP;
			prev_q      <= '0;
			top_q       <= TOP_RST;
			settle_q    <= '0;
			brake_cnt_q <= '0;
			lock_q      <= '0;
			motor_q     <= '0;
			brake_q     <= 1'b0;
			launch_q    <= 1'b0;
		end else if (step) begin
			mode_q      <= mode_d;
			prev_q      <= pot;
			top_q       <= top_d;
			settle_q    <= settle_d;
			brake_cnt_q <= brake_cnt_d;
			lock_q      <= lock_d;
			motor_q     <= motor_d;
			brake_q     <= brake_out;
			launch_q    <= launch_d;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (step) begin
			motor_drive    <= motor_clamped;
			brake_release  <= brake_out;
			mode           <= mode_d;
			launch_enabled <= launch_d;
			top_position   <= top_d[11:0];
		end
	end

endmodule

`default_nettype wire

>>> design/launcher_arm_sequencer_unit.sv
// Top level of the launcher arm sequencer: input register, handshake
// control, configuration bank and sequencer core.
// Depends on las_pkg, las_if, las_cfg and las_core.
//
// Use: one request on the sample channel per control tick carries the
// converter sample and the operator buttons; each request produces exactly
// one request on the result channel with motor command, brake, mode,
// launch flag and the calibrated top reading.
// Path: a sample accepted into the input register is stepped into the
// result register once that register is empty or being emptied, and its
// result is then valid on the result channel.
// Throughput: one request per cycle while the result channel is ready;
// the state update sits between the input register and the result register.
// Stalls: while the result channel is not ready, the held result and one
// accepted sample wait in their registers; sample ready falls only when
// both are full, and nothing is lost or repeated.
// Reset: arst_n clears both registers' valid flags, returns the sequencer
// to top finding with the top at 1500 and loads the register defaults.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once
// and are expected only while no request is in flight.
`default_nettype none

module launcher_arm_sequencer_unit #(
	parameter int SAMPLE_BITS = las_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [las_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [las_pkg::CFG_DATA_W-1:0] cfg_data,
	las_sample_if.sink                          sample,
	las_result_if.source                        result
);
	import las_pkg::*;

	cfg_t                   cfg;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] pot_s1;
	btn_t                   btn_s1;
	logic                   out_valid_q;
	logic                   out_free;
	logic                   step;

	// Handshake: the core steps when the input register holds a request
	// and the result register is empty or being emptied.
	assign out_free     = !out_valid_q || result.ready;
	assign step         = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample.ready) valid_s1 <= sample.valid;
			if (out_free)     out_valid_q <= valid_s1;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			pot_s1                <= sample.pot_sample;
			btn_s1.go_home        <= sample.go_home;
			btn_s1.go_floor       <= sample.go_floor;
			btn_s1.go_idle        <= sample.go_idle;
			btn_s1.arm_request    <= sample.arm_request;
			btn_s1.launch_request <= sample.launch_request;
			btn_s1.override_wheel <= sample.override_wheel;
			btn_s1.override_open  <= sample.override_open;
		end
	end

	las_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	las_core #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.step           (step),
		.pot_sample     (pot_s1),
		.btn            (btn_s1),
		.motor_drive    (result.motor_drive),
		.brake_release  (result.brake_release),
		.mode           (result.mode),
		.launch_enabled (result.launch_enabled),
		.top_position   (result.top_position)
	);

	assign result.valid = out_valid_q;

endmodule

`default_nettype wire

>>> test/launcher_arm_sequencer_unit_tb.sv
// Testbench for launcher_arm_sequencer_unit: directed sequences through every mode,
// then guided random control ticks under changing register settings.
// Depends on las_pkg, las_sample_if and las_result_if from the design folder.

module launcher_arm_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import las_pkg::*;

	localparam int SAMPLE_W    = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_TICKS = 100;

	// Button sets for directed ticks: {home, floor, idle, arm, launch}.
	localparam logic [4:0] B_NONE   = 5'b00000;
	localparam logic [4:0] B_HOME   = 5'b10000;
	localparam logic [4:0] B_FLOOR  = 5'b01000;
	localparam logic [4:0] B_IDLE   = 5'b00100;
	localparam logic [4:0] B_ARM    = 5'b00010;
	localparam logic [4:0] B_LAUNCH = 5'b00001;

	typedef struct packed {
		logic [SAMPLE_W-1:0] pot;
		btn_t                btn;
	} tick_t;

	typedef struct packed {
		logic signed [7:0] motor;
		logic              brake;
		logic [3:0]        mode;
		logic              launch;
		logic [11:0]       top;
	} command_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	las_sample_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
	las_result_if result_ch ();

	launcher_arm_sequencer_unit #(.SAMPLE_BITS(SAMPLE_W)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always #5 clk = ~clk;

	// Predicted sequencer state and the register settings it runs under.
	cfg_t              arm_cfg;
	logic [3:0]        seq_mode;
	logic [11:0]       last_reading;
	logic [11:0]       top_cal;
	logic [7:0]        settle_run;
	logic [7:0]        hold_run;
	logic [7:0]        lock_run;
	int                motor_cmd;
	logic              brake_open;
	logic              launch_on;

	command_t pending_commands[$];
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_len = 0;
	int stall_style = 0;
	int stall_left = 0;

	function automatic logic coin(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic cfg_t reset_settings();
		cfg_t c;
		c.floor_offset     = FLOOR_OFFSET_RST;
		c.home_offset      = HOME_OFFSET_RST;
		c.home_window      = HOME_WINDOW_RST;
		c.top_margin       = TOP_MARGIN_RST;
		c.settle_ticks     = SETTLE_TICKS_RST;
		c.brake_hold_ticks = BRAKE_HOLD_RST;
		c.lock_ticks       = LOCK_TICKS_RST;
		c.home_drive       = HOME_DRIVE_RST;
		return c;
	endfunction

	// Mostly a typical value, sometimes either end of the field's range.
	function automatic int pick_span(input int lo, input int hi, input int typ);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return lo;
		if (roll == 1)
			return hi;
		return lo + int'($urandom_range(0, typ - lo));
	endfunction

	function automatic cfg_t pick_settings();
		cfg_t c;
		c.floor_offset     = 12'(pick_span(0, 4095, 4095));
		c.home_offset      = 12'(pick_span(0, 4095, 4095));
		c.home_window      = 8'(pick_span(0, 255, 80));
		c.top_margin       = 12'(pick_span(0, 4095, 1500));
		c.settle_ticks     = 8'(pick_span(0, 255, 255));
		c.brake_hold_ticks = 8'(pick_span(0, 255, 15));
		c.lock_ticks       = 8'(pick_span(0, 255, 15));
		c.home_drive       = 8'(pick_span(-128, 127, 127));
		return c;
	endfunction

	// One control tick of the sequencer, as the block must compute it.
	function automatic command_t predict_command(input tick_t t);
		command_t c;
		int reading;
		int top;
		int home_pos;
		int floor_pos;
		int m;
		reading   = int'(t.pot) * 4;
		top       = int'(top_cal);
		home_pos  = top - int'(arm_cfg.home_offset);
		floor_pos = top - int'(arm_cfg.floor_offset);

		// The last pressed button in the order home, floor, idle wins.
		if (t.btn.go_home)
			seq_mode = M_HOME;
		if (t.btn.go_floor)
			seq_mode = M_FLOOR;
		if (t.btn.go_idle)
			seq_mode = M_IDLE;
		if (seq_mode != M_LAUNCHING)
			launch_on = 1'b0;

		case (seq_mode)
			M_FIND_TOP: begin
				motor_cmd  = 0;
				brake_open = 1'b1;
				if (reading == int'(last_reading)) begin
					settle_run = settle_run + 8'd1;
					if (settle_run >= arm_cfg.settle_ticks) begin
						top_cal  = reading[11:0];
						seq_mode = M_IDLE;
					end
				end else begin
					settle_run = '0;
				end
			end
			M_HOME: begin
				seq_mode = (reading > home_pos) ? M_HOME_ABOVE : M_HOME_BELOW;
			end
			M_HOME_ABOVE: begin
				brake_open = 1'b1;
				motor_cmd  = int'(arm_cfg.home_drive);
				if (reading <= home_pos + int'(arm_cfg.home_window)) begin
					brake_open = 1'b0;
					if (lock_run > arm_cfg.lock_ticks)
						seq_mode = M_LOCKED;
					lock_run = lock_run + 8'd1;
				end
			end
			M_HOME_BELOW: begin
				seq_mode = M_IDLE;
			end
			M_LOCKED: begin
				lock_run   = '0;
				brake_open = 1'b0;
				motor_cmd  = 0;
			end
			M_FLOOR: begin
				brake_open = 1'b1;
				motor_cmd  = -127;
				if (reading <= floor_pos) begin
					brake_open = 1'b0;
					seq_mode   = M_BRAKING;
					hold_run   = '0;
				end
			end
			M_BRAKING: begin
				brake_open = 1'b0;
				motor_cmd  = -127;
				if (hold_run > arm_cfg.brake_hold_ticks)
					seq_mode = M_LOADED;
				hold_run = hold_run + 8'd1;
			end
			M_LOADED: begin
				hold_run   = '0;
				motor_cmd  = 0;
				brake_open = 1'b0;
				if (t.btn.arm_request)
					seq_mode = M_ARMED;
			end
			M_ARMED: begin
				brake_open = 1'b0;
				motor_cmd  = 0;
				if (t.btn.launch_request)
					seq_mode = M_LAUNCHING;
			end
			M_LAUNCHING: begin
				brake_open = 1'b1;
				launch_on  = 1'b1;
				motor_cmd  = 127;
				if (reading >= top - int'(arm_cfg.top_margin))
					seq_mode = M_IDLE;
			end
			M_IDLE: begin
				motor_cmd  = 0;
				brake_open = 1'b1;
				settle_run = '0;
			end
			default: begin
				seq_mode = M_IDLE;
			end
		endcase
		last_reading = reading[11:0];

		if (t.btn.override_wheel > WHEEL_THRESHOLD)
			brake_open = t.btn.override_open;

		m = motor_cmd;
		if (m > 127)
			m = 127;
		if (m < -127)
			m = -127;
		c.motor  = 8'(m);
		c.brake  = brake_open;
		c.mode   = seq_mode;
		c.launch = launch_on;
		c.top    = top_cal;
		return c;
	endfunction

	function automatic tick_t mk_tick(input int pot, input logic [4:0] buttons,
			input int wheel, input logic open);
		tick_t t;
		t.pot = SAMPLE_W'(pot);
		{t.btn.go_home, t.btn.go_floor, t.btn.go_idle,
			t.btn.arm_request, t.btn.launch_request} = buttons;
		t.btn.override_wheel = 8'(wheel);
		t.btn.override_open  = open;
		return t;
	endfunction

	// Random tick steered by the predicted mode, so that most ticks carry the
	// sequence forward; a few are pure noise or stray button presses.
	function automatic tick_t pick_tick();
		tick_t t;
		int top;
		int aim;
		t = '0;
		if (coin(6)) begin
			t.pot                = SAMPLE_W'($urandom_range(0, 1023));
			t.btn.go_home        = coin(50);
			t.btn.go_floor       = coin(50);
			t.btn.go_idle        = coin(50);
			t.btn.arm_request    = coin(50);
			t.btn.launch_request = coin(50);
			t.btn.override_wheel = 8'($urandom_range(0, 255));
			t.btn.override_open  = coin(50);
			return t;
		end
		top = int'(top_cal);
		t.btn.override_wheel = coin(25) ? 8'($urandom_range(128, 255))
		                                : 8'($urandom_range(0, 127));
		t.btn.override_open  = coin(50);
		t.btn.arm_request    = coin(10);
		t.btn.launch_request = coin(10);
		aim = int'($urandom_range(0, 4095));
		case (seq_mode) inside
			M_IDLE, M_LOCKED, M_HOME_BELOW: begin
				if (coin(50)) begin
					t.btn.go_home = 1'b1;
					aim = top - int'(arm_cfg.home_offset) + int'($urandom_range(0, 400)) - 100;
				end else if (coin(90)) begin
					t.btn.go_floor = 1'b1;
					aim = top - int'(arm_cfg.floor_offset) + 200;
				end
			end
			M_HOME_ABOVE: aim = top - int'(arm_cfg.home_offset) + int'(arm_cfg.home_window);
			M_FLOOR:      aim = top - int'(arm_cfg.floor_offset);
			M_LOADED:     t.btn.arm_request = coin(60);
			M_ARMED:      t.btn.launch_request = coin(60);
			M_LAUNCHING:  aim = top - int'(arm_cfg.top_margin);
			default: ;
		endcase
		// Stray presses also free the sequence from settings that never finish.
		if (coin(4))
			{t.btn.go_home, t.btn.go_floor, t.btn.go_idle} = 3'($urandom_range(1, 7));
		aim = aim + int'($urandom_range(0, 160)) - 80;
		if (aim < 0)
			aim = 0;
		if (aim > 4095)
			aim = 4095;
		t.pot = SAMPLE_W'(aim / 4);
		return t;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < 50)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Compare one accepted result with the oldest predicted command.
	task automatic check_command();
		command_t want;
		if (pending_commands.size() == 0) begin
			flag_mismatch($sformatf("result with none awaited, mode %0d", result_ch.mode));
			return;
		end
		want = pending_commands.pop_front();
		if (result_ch.motor_drive !== want.motor)
			flag_mismatch($sformatf("motor_drive %0d, expected %0d",
				result_ch.motor_drive, want.motor));
		if (result_ch.brake_release !== want.brake)
			flag_mismatch($sformatf("brake_release %0b, expected %0b",
				result_ch.brake_release, want.brake));
		if (result_ch.mode !== want.mode)
			flag_mismatch($sformatf("mode %0d, expected %0d", result_ch.mode, want.mode));
		if (result_ch.launch_enabled !== want.launch)
			flag_mismatch($sformatf("launch_enabled %0b, expected %0b",
				result_ch.launch_enabled, want.launch));
		if (result_ch.top_position !== want.top)
			flag_mismatch($sformatf("top_position %0d, expected %0d",
				result_ch.top_position, want.top));
	endtask

	// Result side: check at each accepted request, then stall on a pattern that
	// switches style whenever its stall count runs out.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			check_command();
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left  = 300;
		end
		stall_left--;
		case (stall_style)
			0:       result_ch.ready <= 1'b1;
			1:       result_ch.ready <= (cycles % 4) != 3;
			2:       result_ch.ready <= coin(50);
			default: result_ch.ready <= ((cycles / 8) % 2) == 0;
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Send one tick request, idling between bursts, and predict its command.
	task automatic send_tick(input tick_t t);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_len    = coin(30) ? 0 : int'($urandom_range(1, 6));
			if (gap_len != 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		burst_left--;
		sample_ch.valid          <= 1'b1;
		sample_ch.pot_sample     <= t.pot;
		sample_ch.go_home        <= t.btn.go_home;
		sample_ch.go_floor       <= t.btn.go_floor;
		sample_ch.go_idle        <= t.btn.go_idle;
		sample_ch.arm_request    <= t.btn.arm_request;
		sample_ch.launch_request <= t.btn.launch_request;
		sample_ch.override_wheel <= t.btn.override_wheel;
		sample_ch.override_open  <= t.btn.override_open;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		pending_commands.push_back(predict_command(t));
	endtask

	// Stop sending and wait until every predicted command has come back.
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (pending_commands.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic write_settings(input cfg_t c);
		write_reg(R_FLOOR_OFFSET, c.floor_offset);
		write_reg(R_HOME_OFFSET, c.home_offset);
		write_reg(R_HOME_WINDOW, {4'h0, c.home_window});
		write_reg(R_TOP_MARGIN, c.top_margin);
		write_reg(R_SETTLE_TICKS, {4'h0, c.settle_ticks});
		write_reg(R_BRAKE_HOLD, {4'h0, c.brake_hold_ticks});
		write_reg(R_LOCK_TICKS, {4'h0, c.lock_ticks});
		write_reg(R_HOME_DRIVE, {4'h0, c.home_drive});
		cfg_we  <= 1'b0;
		arm_cfg  = c;
	endtask

	// Top calibration: a changing reading restarts the count, and with a zero
	// settle count the first unchanged sample is taken as the top.
	task automatic test_find_top();
		send_tick(mk_tick(37, B_NONE, 200, 1'b0));
		send_tick(mk_tick(1000, B_ARM | B_LAUNCH, 127, 1'b1));
		send_tick(mk_tick(1000, B_NONE, 255, 1'b1));
	endtask

	// Homing from above: out of and back into the window, lock, then homing
	// from below, which falls straight through to idle.
	task automatic test_home_sequence();
		send_tick(mk_tick(1000, B_HOME, 0, 1'b0));
		send_tick(mk_tick(1000, B_NONE, 128, 1'b1));
		send_tick(mk_tick(793, B_NONE, 0, 1'b0));
		send_tick(mk_tick(794, B_NONE, 0, 1'b0));
		send_tick(mk_tick(793, B_NONE, 0, 1'b0));
		send_tick(mk_tick(0, B_ARM | B_LAUNCH, 0, 1'b0));
		send_tick(mk_tick(787, B_HOME, 0, 1'b0));
		send_tick(mk_tick(1023, B_NONE, 0, 1'b0));
	endtask

	// Floor, braking, loaded, armed and a launch that stops at the top margin;
	// pressing several buttons at once lets the later one win.
	task automatic test_floor_and_launch();
		send_tick(mk_tick(1000, B_HOME | B_FLOOR, 0, 1'b0));
		send_tick(mk_tick(425, B_NONE, 0, 1'b0));
		send_tick(mk_tick(0, B_NONE, 255, 1'b0));
		send_tick(mk_tick(0, B_LAUNCH, 0, 1'b0));
		send_tick(mk_tick(1, B_ARM, 0, 1'b0));
		send_tick(mk_tick(2, B_LAUNCH, 0, 1'b0));
		send_tick(mk_tick(974, B_NONE, 128, 1'b0));
		send_tick(mk_tick(975, B_NONE, 0, 1'b0));
		send_tick(mk_tick(512, B_HOME | B_FLOOR | B_IDLE, 0, 1'b0));
		send_tick(mk_tick(1023, B_IDLE | B_ARM, 127, 1'b0));
	endtask

	// Random phases, each under its own settings: reset values, both extremes,
	// then random ones.
	task automatic test_random_phases();
		cfg_t c;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: c = reset_settings();
				1: c = '{12'd0, 12'd0, 8'd0, 12'd0, 8'd0, 8'd0, 8'd0, DRIVE_FULL_DOWN};
				2: c = '{12'd4095, 12'd4095, 8'd255, 12'd4095, 8'd255, 8'd255, 8'd255,
				         DRIVE_FULL_UP};
				default: c = pick_settings();
			endcase
			wait_drained();
			write_settings(c);
			for (int n = 0; n < PHASE_TICKS; n++)
				send_tick(pick_tick());
		end
	endtask

	initial begin
		cfg_t c;
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = '0;
		cfg_data                 = '0;
		sample_ch.valid          = 1'b0;
		sample_ch.pot_sample     = '0;
		sample_ch.go_home        = 1'b0;
		sample_ch.go_floor       = 1'b0;
		sample_ch.go_idle        = 1'b0;
		sample_ch.arm_request    = 1'b0;
		sample_ch.launch_request = 1'b0;
		sample_ch.override_wheel = '0;
		sample_ch.override_open  = 1'b0;
		result_ch.ready          = 1'b0;

		// Predicted state after reset.
		arm_cfg      = reset_settings();
		seq_mode     = M_FIND_TOP;
		last_reading = '0;
		top_cal      = 12'(TOP_RESET);
		settle_run   = '0;
		hold_run     = '0;
		lock_run     = '0;
		motor_cmd    = 0;
		brake_open   = 1'b0;
		launch_on    = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short counts keep the directed part brief; the most negative drive tests the clamp.
		c                  = reset_settings();
		c.settle_ticks     = 8'd0;
		c.brake_hold_ticks = 8'd0;
		c.lock_ticks       = 8'd0;
		c.home_drive       = DRIVE_MOST_NEG;
		write_settings(c);

		test_find_top();
		test_home_sequence();
		test_floor_and_launch();
		test_random_phases();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
design/las_pkg.sv
design/las_if.sv
design/las_cfg.sv
design/las_core.sv
design/launcher_arm_sequencer_unit.sv
test/launcher_arm_sequencer_unit_tb.sv
